// ===== src/word_tokenizer_normalizer_assert.svh =====
// Assertion macros for the tokenizer; the word engine (wtn_back) is the module that uses them.
// They assume a clock named i_clk and an active-low reset named i_rst_n.
`ifndef WORD_TOKENIZER_NORMALIZER_ASSERT_SVH
`define WORD_TOKENIZER_NORMALIZER_ASSERT_SVH

`ifndef SYNTHESIS
`define WTN_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("wtn: assertion failed");
`define WTN_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("wtn: assertion failed");
`else
`define WTN_ASSERT_IMP(name, ante, cons)
`define WTN_ASSERT_NEXT(name, ante, cons)
`endif

`endif

// ===== src/wtn_pkg.sv =====
package wtn_pkg;

    localparam int MAX_WORD_LEN_DEF = 64;
    localparam int QUEUE_DEPTH_DEF  = 2;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_HYPHEN = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_QUEST  = 8'h3F;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_Z   = 8'h7A;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    localparam logic [6:0] CASE_BIT = 7'h20;

    // One request from the classifier to the word engine.
    typedef struct packed {
        logic       append;
        logic [6:0] ch;
        logic       flush;
        logic       emit;
    } t_cmd;

    function automatic logic is_sep(input logic [7:0] b);
        logic r;
        case (b) inside
            [CH_TAB:CH_CR], CH_SPACE, CH_DOT, CH_COMMA, CH_SEMI, CH_COLON,
            CH_BANG, CH_QUEST, CH_DQUOTE, CH_SQUOTE, CH_LPAREN, CH_RPAREN,
            CH_LBRACK, CH_RBRACK, CH_LBRACE, CH_RBRACE: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    // Zero means the byte is dropped.
    function automatic logic [6:0] norm_char(input logic [7:0] b);
        logic [6:0] r;
        case (b) inside
            [CH_UP_A:CH_UP_Z]: r = b[6:0] | CASE_BIT;
            [CH_LO_A:CH_LO_Z], [CH_ZERO:CH_NINE], CH_HYPHEN, CH_UNDER: r = b[6:0];
            default: r = 7'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== src/wtn_front.sv =====
module wtn_front import wtn_pkg::*; #(
    parameter int MAX_WORD_LEN = MAX_WORD_LEN_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_text_byte,
    input  logic       i_end_of_text,
    output logic       o_stall,
    input  logic       i_q_full,
    output logic       o_push,
    output t_cmd       o_cmd
);

    localparam int RW = $clog2(MAX_WORD_LEN + 1);

    logic [RW-1:0] r_raw, n_raw;
    logic          r_kept_any, n_kept_any;
    logic          accept, sep, raw_below, raw_room, kept_nx;
    logic [6:0]    ch;
    logic [RW-1:0] raw_inc;
    t_cmd          cmd;

    always_comb begin
        accept    = i_valid && !i_q_full;
        sep       = is_sep(i_text_byte);
        ch        = norm_char(i_text_byte);
        raw_below = r_raw < RW'(MAX_WORD_LEN);
        raw_room  = r_raw < RW'(MAX_WORD_LEN - 1);
        raw_inc   = raw_below ? r_raw + RW'(1) : r_raw;
        cmd        = '0;
        cmd.ch     = ch;
        kept_nx    = r_kept_any;
        n_raw      = r_raw;
        n_kept_any = r_kept_any;
        if (sep) begin
            cmd.flush  = 1'b1;
            cmd.emit   = r_kept_any && raw_below;
            n_raw      = '0;
            n_kept_any = 1'b0;
        end else begin
            // A byte that brings the raw length to the limit is not stored.
            cmd.append = raw_room && (ch != 7'd0);
            kept_nx    = r_kept_any || cmd.append;
            if (i_end_of_text) begin
                cmd.flush  = 1'b1;
                cmd.emit   = kept_nx && raw_room;
                n_raw      = '0;
                n_kept_any = 1'b0;
            end else begin
                n_raw      = raw_inc;
                n_kept_any = kept_nx;
            end
        end
    end

    assign o_stall = i_q_full;
    assign o_push  = accept && (cmd.append || cmd.flush);
    assign o_cmd   = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw      <= '0;
            r_kept_any <= 1'b0;
        end else if (accept) begin
            r_raw      <= n_raw;
            r_kept_any <= n_kept_any;
        end
    end

endmodule

// ===== src/wtn_queue.sv =====
module wtn_queue import wtn_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_slot [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_full  = r_cnt == CW'(DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_cmd   = r_slot[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

// ===== src/wtn_back.sv =====
`include "word_tokenizer_normalizer_assert.svh"

module wtn_back import wtn_pkg::*; #(
    parameter int MAX_WORD_LEN = MAX_WORD_LEN_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    input  logic       i_empty,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [6:0] o_word_char,
    output logic       o_word_last
);

    localparam int DEPTH = MAX_WORD_LEN - 1;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int KW    = $clog2(MAX_WORD_LEN);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EMIT = 2'b10
    } t_bstate;

    t_bstate       r_state, n_state;
    logic [KW-1:0] r_wp, n_wp, r_rp, n_rp, r_len, n_len;
    logic [6:0]    r_buf [DEPTH];
    logic [6:0]    r_rd_data, r_out_char;
    logic          r_rd_last, r_rd_pend, r_out_valid, r_out_last;
    logic          out_free, pop, wr_en, rd_issue;

    always_comb begin
        out_free = !r_out_valid || !i_stall;
        pop      = (r_state == S_IDLE) && !i_empty;
        wr_en    = pop && i_cmd.append;
        rd_issue = (r_state == S_EMIT) && (r_rp != r_len) && (!r_rd_pend || out_free);
        n_state  = r_state;
        n_wp     = r_wp;
        n_rp     = r_rp;
        n_len    = r_len;
        unique case (r_state)
            S_IDLE: begin
                if (pop) begin
                    if (i_cmd.flush) begin
                        n_wp = '0;
                        if (i_cmd.emit) begin
                            n_len   = r_wp + KW'(i_cmd.append);
                            n_rp    = '0;
                            n_state = S_EMIT;
                        end
                    end else if (wr_en) begin
                        n_wp = r_wp + KW'(1);
                    end
                end
            end
            S_EMIT: begin
                if (rd_issue) begin
                    n_rp = r_rp + KW'(1);
                    if (r_rp == r_len - KW'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Word buffer: written while a word builds, read out once it closes.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_buf[r_wp[AW-1:0]] <= i_cmd.ch;
        end
        if (rd_issue) begin
            r_rd_data <= r_buf[r_rp[AW-1:0]];
            r_rd_last <= r_rp == r_len - KW'(1);
        end
        if (out_free && r_rd_pend) begin
            r_out_char <= r_rd_data;
            r_out_last <= r_rd_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wp        <= '0;
            r_rp        <= '0;
            r_len       <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_len   <= n_len;
            if (rd_issue) begin
                r_rd_pend <= 1'b1;
            end else if (out_free) begin
                r_rd_pend <= 1'b0;
            end
            if (out_free) begin
                r_out_valid <= r_rd_pend;
            end
        end
    end

    assign o_pop       = pop;
    assign o_valid     = r_out_valid;
    assign o_word_char = r_out_char;
    assign o_word_last = r_out_last;

    `WTN_ASSERT_IMP(a_wr_in_range, wr_en, r_wp < KW'(DEPTH))
    `WTN_ASSERT_IMP(a_rd_in_range, rd_issue, r_rp < r_len)
    `WTN_ASSERT_NEXT(a_pend_held, r_rd_pend && !out_free, r_rd_pend && $stable(r_rd_data))
    `WTN_ASSERT_IMP(a_emit_nonempty, pop && i_cmd.emit, i_cmd.flush && (r_wp != '0 || i_cmd.append))

endmodule

// ===== src/word_tokenizer_normalizer.sv =====
// Splits a byte stream into lowercase words and streams out their characters.
// Input channel: i_valid / o_stall with i_text_byte and i_end_of_text; a byte
// is taken at a clock edge where i_valid is high and o_stall is low. Set
// i_end_of_text on the final byte of a text to close any open word.
// Output channel: o_valid / i_stall with o_word_char and o_word_last; one
// character per request, o_word_last high on the final character of a word.
// The classifier takes one byte per cycle, while the queue has room, into a
// short command queue. The word engine drains that queue one command per cycle
// while a word builds, and closing a word occupies it for one buffer read per
// character, during which it takes no commands. Bytes keep arriving while the
// queue has room. The first character of a word passes through the queue, the
// engine state register, the buffer read stage and the output register after
// the byte that closed it.
// A synchronous reset (i_rst_n low) empties the queue, drops any open word
// and clears the output valid flag; the buffer itself needs no clearing.
// When the receiver stalls, the current character holds and one more sits in
// the read stage; after that the engine waits, the queue fills and o_stall
// rises.
module word_tokenizer_normalizer import wtn_pkg::*; #(
    parameter int MAX_WORD_LEN = MAX_WORD_LEN_DEF,
    parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_text_byte,
    input  logic       i_end_of_text,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [6:0] o_word_char,
    output logic       o_word_last
);

    logic q_full, q_empty, push, pop;
    t_cmd push_cmd, pop_cmd;

    wtn_front #(
        .MAX_WORD_LEN (MAX_WORD_LEN)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_text_byte   (i_text_byte),
        .i_end_of_text (i_end_of_text),
        .o_stall       (o_stall),
        .i_q_full      (q_full),
        .o_push        (push),
        .o_cmd         (push_cmd)
    );

    wtn_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_cmd   (pop_cmd),
        .o_empty (q_empty)
    );

    wtn_back #(
        .MAX_WORD_LEN (MAX_WORD_LEN)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (pop_cmd),
        .i_empty     (q_empty),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_word_char (o_word_char),
        .o_word_last (o_word_last)
    );

endmodule

// ===== test/word_tokenizer_checker.sv =====
`timescale 1ns / 100ps

module word_tokenizer_checker import wtn_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_byte_valid,
    input  logic       i_byte_stall,
    input  logic [7:0] i_text_byte,
    input  logic       i_end_of_text,
    input  logic       i_char_valid,
    input  logic       i_char_stall,
    input  logic [6:0] i_word_char,
    input  logic       i_word_last,
    output int         o_errors,
    output int         o_pending
);

    localparam int WORD_LIMIT = MAX_WORD_LEN_DEF;
    localparam int HOLD_DEPTH = MAX_WORD_LEN_DEF - 1;

    typedef struct packed {
        logic [6:0] ch;
        logic       last;
    } t_word_beat;

    t_word_beat expected_chars[$];
    logic [6:0] held_chars[HOLD_DEPTH];
    int         raw_count   = 0;
    int         held_count  = 0;
    int         error_count = 0;
    t_word_beat oldest;

    function automatic bit splits_word(input logic [7:0] b);
        return (b >= CH_TAB && b <= CH_CR) || b == CH_SPACE || b == CH_DOT ||
               b == CH_COMMA || b == CH_SEMI || b == CH_COLON || b == CH_BANG ||
               b == CH_QUEST || b == CH_DQUOTE || b == CH_SQUOTE ||
               b == CH_LPAREN || b == CH_RPAREN || b == CH_LBRACK ||
               b == CH_RBRACK || b == CH_LBRACE || b == CH_RBRACE;
    endfunction

    // Zero stands for a byte that is not kept.
    function automatic logic [6:0] fold_case(input logic [7:0] b);
        if (b >= CH_UP_A && b <= CH_UP_Z)
            return b[6:0] + 7'd32;
        if ((b >= CH_LO_A && b <= CH_LO_Z) || (b >= CH_ZERO && b <= CH_NINE) ||
            b == CH_HYPHEN || b == CH_UNDER)
            return b[6:0];
        return 7'd0;
    endfunction

    // A word is emitted only if it stayed short and kept at least one character.
    task automatic close_word();
        t_word_beat beat;
        if (raw_count > 0 && raw_count < WORD_LIMIT && held_count > 0) begin
            for (int k = 0; k < held_count; k++) begin
                beat.ch   = held_chars[k];
                beat.last = (k == held_count - 1);
                expected_chars.push_back(beat);
            end
        end
        raw_count  = 0;
        held_count = 0;
    endtask

    task automatic take_byte(input logic [7:0] b, input logic eot);
        logic [6:0] c;
        if (splits_word(b)) begin
            close_word();
        end else begin
            if (raw_count < WORD_LIMIT) begin
                raw_count++;
                if (raw_count < WORD_LIMIT) begin
                    c = fold_case(b);
                    if (c != 7'd0 && held_count < HOLD_DEPTH) begin
                        held_chars[held_count] = c;
                        held_count++;
                    end
                end
            end
            if (eot)
                close_word();
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            raw_count  = 0;
            held_count = 0;
            expected_chars.delete();
        end else begin
            if (i_byte_valid && !i_byte_stall)
                take_byte(i_text_byte, i_end_of_text);
            if (i_char_valid && !i_char_stall) begin
                if (expected_chars.size() == 0) begin
                    $error("word_char: expected none, got %0h (word_last %0b)",
                           i_word_char, i_word_last);
                    error_count++;
                end else begin
                    oldest = expected_chars.pop_front();
                    if (i_word_char !== oldest.ch) begin
                        $error("word_char: expected %0h, got %0h", oldest.ch, i_word_char);
                        error_count++;
                    end
                    if (i_word_last !== oldest.last) begin
                        $error("word_last: expected %0b, got %0b", oldest.last, i_word_last);
                        error_count++;
                    end
                end
            end
        end
        o_pending <= expected_chars.size();
        o_errors  <= error_count;
    end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top import wtn_pkg::*; ();

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_valid       = 1'b0;
    logic [7:0] i_text_byte   = CH_SPACE;
    logic       i_end_of_text = 1'b0;
    logic       i_stall       = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [6:0] o_word_char;
    logic       o_word_last;
    int         errors;
    int         pending;

    bit         quiet      = 1'b0;
    int         sent_count = 0;
    int         word_count = 0;

    logic [7:0] separators[19] = '{
        CH_TAB, 8'h0A, 8'h0B, 8'h0C, CH_CR, CH_SPACE, CH_DOT, CH_COMMA, CH_SEMI,
        CH_COLON, CH_BANG, CH_QUEST, CH_DQUOTE, CH_SQUOTE, CH_LPAREN, CH_RPAREN,
        CH_LBRACK, CH_RBRACK, CH_LBRACE
    };
    // Bytes below 128 that are neither separators nor kept.
    logic [7:0] dropped_low[7] = '{8'h01, 8'h08, 8'h23, 8'h40, 8'h5C, 8'h7E, 8'h7F};

    word_tokenizer_normalizer DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_text_byte   (i_text_byte),
        .i_end_of_text (i_end_of_text),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_word_char   (o_word_char),
        .o_word_last   (o_word_last)
    );

    word_tokenizer_checker CHK (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_byte_valid  (i_valid),
        .i_byte_stall  (o_stall),
        .i_text_byte   (i_text_byte),
        .i_end_of_text (i_end_of_text),
        .i_char_valid  (o_valid),
        .i_char_stall  (i_stall),
        .i_word_char   (o_word_char),
        .i_word_last   (o_word_last),
        .o_errors      (errors),
        .o_pending     (pending)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_stall <= !quiet && ($urandom_range(0, 99) < 26);
    end

    initial begin
        #2_000_000;
        $display("tb_top: errors");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b, input logic eot);
        if (!quiet) begin
            while ($urandom_range(0, 99) < 26) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_valid       <= 1'b1;
        i_text_byte   <= b;
        i_end_of_text <= eot;
        do @(posedge i_clk); while (o_stall);
        sent_count++;
    endtask

    // Holds the input back until every predicted character has come out.
    // The count is read at the falling edge, once the last request is in it.
    task automatic drain_words();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    function automatic logic [7:0] word_byte(input bit clean);
        int pick;
        pick = clean ? $urandom_range(0, 82) : $urandom_range(0, 99);
        if (pick < 25)
            return 8'($urandom_range(CH_UP_A, CH_UP_Z));
        if (pick < 60)
            return 8'($urandom_range(CH_LO_A, CH_LO_Z));
        if (pick < 75)
            return 8'($urandom_range(CH_ZERO, CH_NINE));
        if (pick < 83)
            return pick[0] ? CH_HYPHEN : CH_UNDER;
        if (pick < 92)
            return 8'($urandom_range(128, 255));
        return dropped_low[$urandom_range(0, 6)];
    endfunction

    task automatic send_word(input int len, input bit clean);
        int ending;
        ending = $urandom_range(0, 99);
        for (int i = 0; i < len; i++)
            send_byte(word_byte(clean), (ending < 15) && (i == len - 1));
        if (ending >= 15)
            send_byte(separators[$urandom_range(0, 18)], ending < 25);
        word_count++;
    endtask

    initial begin
        int start_count;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Every kind of kept character plus a high byte, closed by a space.
        send_byte(CH_UP_A, 1'b0);
        send_byte(CH_UP_Z, 1'b0);
        send_byte(CH_LO_A, 1'b0);
        send_byte(CH_LO_Z, 1'b0);
        send_byte(CH_ZERO, 1'b0);
        send_byte(CH_NINE, 1'b0);
        send_byte(CH_HYPHEN, 1'b0);
        send_byte(CH_UNDER, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(CH_SPACE, 1'b0);
        // A lone separator, then a word made only of dropped bytes.
        send_byte(CH_TAB, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(CH_CR, 1'b0);
        // The final byte of a text closes the word, kept or not.
        send_byte(8'h51, 1'b1);
        send_byte(8'h78, 1'b0);
        send_byte(CH_RBRACE, 1'b1);
        send_byte(8'h7F, 1'b1);
        send_byte(8'h4D, 1'b0);
        send_byte(CH_HYPHEN, 1'b0);
        send_byte(CH_DQUOTE, 1'b0);
        drain_words();

        // The longest word that is still emitted, then one that runs past the limit.
        send_word(MAX_WORD_LEN_DEF - 1, 1'b1);
        send_word(MAX_WORD_LEN_DEF + 1, 1'b0);
        drain_words();

        start_count = sent_count;
        word_count  = 0;
        while (sent_count - start_count < 35) begin
            quiet = (sent_count - start_count >= 10) && (sent_count - start_count < 28);
            if ($urandom_range(0, 99) < 80) begin
                if ($urandom_range(0, 29) == 0)
                    send_word($urandom_range(55, 70), 1'b0);
                else
                    send_word($urandom_range(1, 10), 1'b0);
            end else begin
                repeat ($urandom_range(1, 4))
                    send_byte(8'($urandom_range(1, 255)), $urandom_range(0, 9) == 0);
            end
            if (word_count == 6)
                drain_words();
        end
        quiet = 1'b0;

        i_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (40) @(posedge i_clk);
        if (errors == 0 && pending == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
